[hw/rtl/scan_cycle_delay_timer_bank_unit_defines.svh]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank: assertion macros
// shared property shorthands, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SCAN_CYCLE_DELAY_TIMER_BANK_UNIT_DEFINES_SVH
`define SCAN_CYCLE_DELAY_TIMER_BANK_UNIT_DEFINES_SVH

// same-cycle implication
`define SCDT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scdt: same-cycle check failed");

// next-cycle implication
`define SCDT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scdt: next-cycle check failed");

`endif

[hw/rtl/scdt_pkg.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank: package
// field widths, function codes and the per-access operation descriptor
// ----------------------------------------------------------------------------
package scdt_pkg;

	localparam int FUNC_W     = 2;
	localparam int ID_W       = 6;
	localparam int DELAY_W    = 20;
	localparam int ELAPSED_W  = 16;
	// a preset in seconds reaches 1048575 * 1000, below 2**30
	localparam int PRESET_W   = 30;
	localparam int MS_PER_SEC = 1000;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CYCLE = 2'd0,
		FUNC_ON    = 2'd1,
		FUNC_OFF   = 2'd2,
		FUNC_PULSE = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic  start;
		logic  sweep;
	} scdt_op_t;

endpackage

[hw/rtl/scdt_req_if.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank: request channel
// valid/ready handshake carrying one timer access or cycle update
// ----------------------------------------------------------------------------
interface scdt_req_if
	import scdt_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [ID_W-1:0]      timer_id;
	logic                 start_req;
	logic [DELAY_W-1:0]   delay_value;
	logic                 unit_seconds;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (
		output valid, func, timer_id, start_req, delay_value, unit_seconds, elapsed_ms,
		input  ready
	);

	modport sink (
		input  valid, func, timer_id, start_req, delay_value, unit_seconds, elapsed_ms,
		output ready
	);
endinterface

[hw/rtl/scdt_rsp_if.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank: response channel
// valid/ready handshake carrying the timer output level
// ----------------------------------------------------------------------------
interface scdt_rsp_if
	import scdt_pkg::*;
();
	logic valid;
	logic ready;
	logic timer_out;

	modport source (
		output valid, timer_out,
		input  ready
	);

	modport sink (
		input  valid, timer_out,
		output ready
	);
endinterface

[hw/rtl/scan_cycle_delay_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank unit
// timer access: ram read at acceptance, update, write back and response load
//   in ST_EXEC once the response register is free; no new request until idle
// cycle update: sweep over the count ram, response loaded once the last entry
//   is written back; one request in flight at a time; a held response stalls both
// reset: clearing pass over every ram entry before req.ready rises
// ----------------------------------------------------------------------------
`include "scan_cycle_delay_timer_bank_unit_defines.svh"

module scan_cycle_delay_timer_bank_unit
	import scdt_pkg::*;
#(
	parameter int NUM_TIMERS  = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	scdt_req_if.sink    req,
	scdt_rsp_if.source  rsp
);
	// ram address width, sweep pointer width (it also holds NUM_TIMERS)
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int PW = $clog2(NUM_TIMERS + 1);
	localparam int IW = (AW > ID_W) ? AW : ID_W;
	// ram entry: activity mark on top of the count
	localparam int EW = COUNT_WIDTH + 1;
	localparam logic [PW-1:0] PTR_END  = PW'(NUM_TIMERS);
	localparam logic [PW-1:0] PTR_LAST = PW'(NUM_TIMERS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [PW-1:0]        ptr_q, ptr_d;
	logic [ELAPSED_W-1:0] cycle_time_q;

	// access stage, filled at acceptance
	scdt_op_t             op_s1;
	logic                 in_range_s1;
	logic [AW-1:0]        addr_s1;
	logic [PRESET_W-1:0]  preset_s1;

	// sweep write-back stage, one behind the sweep read
	logic                 sweep_v_s1;
	logic [AW-1:0]        sweep_addr_s1;

	logic                 rsp_valid_q;
	logic                 timer_out_q;

	logic                 req_acc;
	logic                 rsp_free;
	logic                 rsp_load;
	logic                 rsp_bit;
	logic                 in_range;
	logic [IW-1:0]        id_wide;
	logic [PRESET_W-1:0]  preset_d;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [EW-1:0]        ram_rdata;

	scdt_op_t             upd_op;
	logic [EW-1:0]        upd_entry;
	logic                 upd_hit;

	// handshakes: a new request may be taken while the last response waits
	assign req.ready   = (state_q == ST_IDLE);
	assign req_acc     = req.valid && req.ready;
	assign rsp_free    = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.timer_out = timer_out_q;

	// timer number check and ram address of the accessed timer
	assign id_wide  = IW'(req.timer_id);
	assign in_range = (32'(req.timer_id) < 32'(NUM_TIMERS));

	// preset in ms, seconds scaled here so the update stage sees one compare
	assign preset_d = req.unit_seconds
		? (PRESET_W'(req.delay_value) * PRESET_W'(MS_PER_SEC))
		: PRESET_W'(req.delay_value);

	// count and mark store
	scdt_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_TIMERS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// the same update logic serves accesses and the sweep
	always_comb begin
		upd_op       = op_s1;
		upd_op.sweep = (state_q == ST_SWEEP);
	end

	scdt_update #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_update (
		.op         (upd_op),
		.entry_in   (ram_rdata),
		.preset     (preset_s1),
		.cycle_time (cycle_time_q),
		.entry_out  (upd_entry),
		.hit        (upd_hit)
	);

	// sequencer: one request in flight at a time, so no two ram accesses to
	// the same entry overlap; the sweep reads entry n while writing entry n-1
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = upd_entry;
		ram_re    = 1'b0;
		ram_raddr = id_wide[AW-1:0];
		rsp_load  = 1'b0;
		rsp_bit   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				// counts and marks to zero after reset
				ram_we    = 1'b1;
				ram_waddr = ptr_q[AW-1:0];
				ram_wdata = '0;
				ptr_d     = ptr_q + PW'(1);
				if (ptr_q == PTR_LAST) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_acc) begin
					if (func_t'(req.func) == FUNC_CYCLE) begin
						state_d = ST_SWEEP;
					end else begin
						ram_re  = in_range;
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				// stall here until the response register is free
				if (rsp_free) begin
					ram_we   = in_range_s1;
					rsp_load = 1'b1;
					rsp_bit  = upd_hit && in_range_s1;
					state_d  = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (ptr_q != PTR_END) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q[AW-1:0];
					ptr_d     = ptr_q + PW'(1);
				end
				if (sweep_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = sweep_addr_s1;
				end
				if ((ptr_q == PTR_END) && !sweep_v_s1 && rsp_free) begin
					rsp_load = 1'b1;
					ptr_d    = '0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			sweep_v_s1   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			cycle_time_q <= '0;
		end else begin
			state_q    <= state_d;
			ptr_q      <= ptr_d;
			sweep_v_s1 <= (state_q == ST_SWEEP) && (ptr_q != PTR_END);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			// elapsed time latched for the scan that follows
			if (req_acc && (func_t'(req.func) == FUNC_CYCLE)) begin
				cycle_time_q <= req.elapsed_ms;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		sweep_addr_s1 <= ptr_q[AW-1:0];
		if (req_acc) begin
			op_s1.func  <= func_t'(req.func);
			op_s1.start <= req.start_req;
			op_s1.sweep <= 1'b0;
			in_range_s1 <= in_range;
			addr_s1     <= id_wide[AW-1:0];
			preset_s1   <= preset_d;
		end
		if (rsp_load) begin
			timer_out_q <= rsp_bit;
		end
	end

	// a timer access always goes to the update stage next
	`SCDT_ASSERT_NXT(a_access_to_exec, req_acc && (func_t'(req.func) != FUNC_CYCLE), state_q == ST_EXEC)
	// sweep read and write-back never hit the same entry
	`SCDT_ASSERT_IMP(a_sweep_no_collide, ram_we && ram_re, ram_waddr != ram_raddr)
	// a sweep write-back only exists while sweeping
	`SCDT_ASSERT_IMP(a_sweep_stage_in_sweep, sweep_v_s1, state_q == ST_SWEEP)

endmodule

[hw/rtl/scdt_ram.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank: generic ram
// one write port, one read port, read data registered, held while not read
// ----------------------------------------------------------------------------
module scdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hw/rtl/scdt_update.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank: entry update
// next count, mark and output level for one timer entry read from the ram
// ----------------------------------------------------------------------------
module scdt_update
	import scdt_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  scdt_op_t               op,
	input  logic [COUNT_WIDTH:0]   entry_in,
	input  logic [PRESET_W-1:0]    preset,
	input  logic [ELAPSED_W-1:0]   cycle_time,
	output logic [COUNT_WIDTH:0]   entry_out,
	output logic                   hit
);
	localparam int CW = COUNT_WIDTH;
	localparam int XW = ((CW > PRESET_W) ? CW : PRESET_W) + 1;

	logic [CW-1:0] cnt;
	logic          mark;
	logic [CW-1:0] cnt_max;
	logic [CW-1:0] ct;
	logic [CW:0]   sum_w;
	logic [CW-1:0] sum_sat;
	logic          sum_ge;
	logic [CW-1:0] preset_sat;
	logic [CW-1:0] dec;
	logic [CW-1:0] cnt_new;

	assign cnt        = entry_in[CW-1:0];
	assign mark       = entry_in[CW];
	assign cnt_max    = '1;
	assign ct         = CW'(cycle_time);
	assign sum_w      = {1'b0, cnt} + {1'b0, ct};
	assign sum_sat    = sum_w[CW] ? cnt_max : sum_w[CW-1:0];
	assign sum_ge     = XW'(sum_sat) >= XW'(preset);
	assign preset_sat = (XW'(preset) > XW'(cnt_max)) ? cnt_max : CW'(preset);
	// off-delay countdown stops at zero
	assign dec        = (cnt > ct) ? (cnt - ct) : '0;

	always_comb begin
		cnt_new = cnt;
		hit     = 1'b0;
		case (op.func)
			FUNC_OFF: begin
				if (op.start) begin
					cnt_new = preset_sat;
					hit     = 1'b1;
				end else if (cnt != '0) begin
					cnt_new = dec;
					hit     = 1'b1;
				end
			end
			FUNC_ON, FUNC_PULSE: begin
				if (op.start) begin
					cnt_new = sum_sat;
					if (sum_ge) begin
						hit = 1'b1;
						if (op.func == FUNC_PULSE) begin
							cnt_new = '0;
						end
					end
				end else begin
					cnt_new = '0;
				end
			end
			default: begin
				cnt_new = cnt;
			end
		endcase
		if (op.sweep) begin
			// untouched timers lose their count, every mark drops
			entry_out = {1'b0, (mark ? cnt : '0)};
			hit       = 1'b0;
		end else begin
			entry_out = {1'b1, cnt_new};
		end
	end
endmodule

[verif/scan_cycle_delay_timer_bank_unit_tb.sv]
// ----------------------------------------------------------------------------
// scan cycle delay timer bank unit: testbench
// sends a directed opening followed by random scans (a cycle update and then
// accesses to a small working set of timers, with some random noise between).
// Every accepted request is run through a local copy of the timer bank, and
// each response is checked in order against the predicted output level.
// ----------------------------------------------------------------------------
module scan_cycle_delay_timer_bank_unit_tb;
	import scdt_pkg::*;

	localparam int          NUM_TIMERS   = 64;
	localparam int          COUNT_W      = 32;
	localparam logic [63:0] COUNT_MAX    = (64'd1 << COUNT_W) - 64'd1;
	localparam int          ITEM_TARGET  = 1650;
	localparam int          QUIET_TAIL   = 150;
	// longest single request is a sweep over all NUM_TIMERS entries
	localparam int          DRAIN_CYCLES = NUM_TIMERS + 40;
	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          HOLD_START   = 1500;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          WORK_SET     = 8;

	typedef struct packed {
		func_t                func;
		logic [ID_W-1:0]      timer_id;
		logic                 start_req;
		logic [DELAY_W-1:0]   delay_value;
		logic                 unit_seconds;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} timer_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	scdt_req_if req_ch ();
	scdt_rsp_if rsp_ch ();

	scan_cycle_delay_timer_bank_unit #(
		.NUM_TIMERS  (NUM_TIMERS),
		.COUNT_WIDTH (COUNT_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// requests still to be sent, and output levels still to be seen
	timer_req_t pending_reqs[$];
	logic       expected_levels[$];

	// local copy of the bank state
	logic [COUNT_W-1:0]   timer_count [NUM_TIMERS];
	logic                 timer_mark  [NUM_TIMERS];
	logic [ELAPSED_W-1:0] scan_ms;

	int unsigned faults = 0;

	// shared pacing flags, all updated with nonblocking assignments
	logic quiet    = 1'b0;
	logic calm     = 1'b0;
	logic rsp_hold = 1'b0;

	initial begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			timer_count[i] = '0;
			timer_mark[i]  = 1'b0;
		end
		scan_ms = '0;
	end

	// ------------------------------------------------------------------
	// bank predictor: applies one request, returns the expected level
	// ------------------------------------------------------------------
	function automatic logic apply_timer_req(input timer_req_t r);
		logic [63:0] preset;
		logic [63:0] acc;
		logic        fired;
		int          idx;
		fired  = 1'b0;
		preset = 64'(r.delay_value);
		if (r.unit_seconds)
			preset = preset * 64'(MS_PER_SEC);
		// cycle update: latch scan time, clear untouched timers, drop all marks
		if (r.func == FUNC_CYCLE) begin
			scan_ms = r.elapsed_ms;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (!timer_mark[i])
					timer_count[i] = '0;
				timer_mark[i] = 1'b0;
			end
			return 1'b0;
		end
		// out-of-range timer: ignored, level low
		if (int'(r.timer_id) >= NUM_TIMERS)
			return 1'b0;
		idx = int'(r.timer_id);
		if (r.func == FUNC_OFF) begin
			if (r.start_req) begin
				timer_count[idx] = (preset > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
					: preset[COUNT_W-1:0];
				fired = 1'b1;
			end else if (timer_count[idx] != '0) begin
				fired = 1'b1;
				// count-down stops at zero
				if (timer_count[idx] > COUNT_W'(scan_ms))
					timer_count[idx] = timer_count[idx] - COUNT_W'(scan_ms);
				else
					timer_count[idx] = '0;
			end
		end else begin
			if (r.start_req) begin
				acc = 64'(timer_count[idx]);
				acc = acc + 64'(scan_ms);
				timer_count[idx] = (acc > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
					: acc[COUNT_W-1:0];
				acc = 64'(timer_count[idx]);
				if (acc >= preset) begin
					fired = 1'b1;
					if (r.func == FUNC_PULSE)
						timer_count[idx] = '0;
				end
			end else begin
				timer_count[idx] = '0;
			end
		end
		timer_mark[idx] = 1'b1;
		return fired;
	endfunction

	// request builders; fields a request ignores get random content
	function automatic timer_req_t timer_access(input func_t f, input int unsigned id,
			input logic start, input int unsigned delay, input logic secs);
		timer_req_t r;
		r.func         = f;
		r.timer_id     = id[ID_W-1:0];
		r.start_req    = start;
		r.delay_value  = delay[DELAY_W-1:0];
		r.unit_seconds = secs;
		r.elapsed_ms   = ELAPSED_W'($urandom_range(0, 65535));
		return r;
	endfunction

	function automatic timer_req_t scan_update(input int unsigned elapsed);
		timer_req_t r;
		r.func         = FUNC_CYCLE;
		r.timer_id     = ID_W'($urandom_range(0, 63));
		r.start_req    = 1'($urandom_range(0, 1));
		r.delay_value  = DELAY_W'($urandom_range(0, 20'hFFFFF));
		r.unit_seconds = 1'($urandom_range(0, 1));
		r.elapsed_ms   = elapsed[ELAPSED_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------
	timer_req_t  in_flight;
	int unsigned send_gap     = 0;
	int unsigned stretch_cnt  = 0;

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.func         = '0;
		req_ch.timer_id     = '0;
		req_ch.start_req    = 1'b0;
		req_ch.delay_value  = '0;
		req_ch.unit_seconds = 1'b0;
		req_ch.elapsed_ms   = '0;
		rsp_ch.ready        = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			stretch_cnt++;
			// alternate stretches of random idling and none at all
			calm  <= stretch_cnt[8];
			quiet <= (pending_reqs.size() < QUIET_TAIL);
			// request taken at this edge: predict its response
			if (req_ch.valid && req_ch.ready)
				expected_levels.push_back(apply_timer_req(in_flight));
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
					// idle burst, this one included
					send_gap = $urandom_range(0, 4);
					req_ch.valid <= 1'b0;
				end else begin
					in_flight = pending_reqs.pop_front();
					req_ch.func         <= in_flight.func;
					req_ch.timer_id     <= in_flight.timer_id;
					req_ch.start_req    <= in_flight.start_req;
					req_ch.delay_value  <= in_flight.delay_value;
					req_ch.unit_seconds <= in_flight.unit_seconds;
					req_ch.elapsed_ms   <= in_flight.elapsed_ms;
					req_ch.valid        <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// long receiver hold-off, so the block backs up and stalls requests
	// ------------------------------------------------------------------
	int unsigned hold_clock = 0;
	int unsigned hold_left  = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			hold_clock = 0;
			hold_left  = 0;
			rsp_hold <= 1'b0;
		end else begin
			hold_clock++;
			if (hold_clock == HOLD_START) begin
				hold_left = HOLD_CYCLES;
				rsp_hold <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					rsp_hold <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// response monitor and checker
	// ------------------------------------------------------------------
	int unsigned recv_gap = 0;
	logic        want_level;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: response with no request outstanding, expected none, got %0b",
						$time, rsp_ch.timer_out);
					faults++;
				end else begin
					want_level = expected_levels.pop_front();
					if (rsp_ch.timer_out !== want_level) begin
						$display("%0t: timer_out expected %0b, got %0b",
							$time, want_level, rsp_ch.timer_out);
						faults++;
					end
				end
			end
			if (rsp_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 4);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	int unsigned cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("scan_cycle_delay_timer_bank_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned slot_id    [WORK_SET];
		func_t       slot_func  [WORK_SET];
		logic        slot_start [WORK_SET];
		int unsigned slot_delay [WORK_SET];
		logic        slot_secs  [WORK_SET];
		int unsigned elapsed_top;
		int unsigned scans;
		int unsigned burst;

		// directed opening
		pending_reqs.push_back(scan_update(100));
		// zero preset fires at once
		pending_reqs.push_back(timer_access(FUNC_ON, 0, 1'b1, 0, 1'b0));
		// largest preset in seconds, top timer
		pending_reqs.push_back(timer_access(FUNC_ON, 63, 1'b1, 20'hFFFFF, 1'b1));
		pending_reqs.push_back(timer_access(FUNC_OFF, 1, 1'b1, 20'hFFFFF, 1'b1));
		pending_reqs.push_back(timer_access(FUNC_PULSE, 2, 1'b1, 150, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_OFF, 3, 1'b1, 50, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_OFF, 4, 1'b1, 0, 1'b0));
		pending_reqs.push_back(scan_update(16'hFFFF));
		// one-shot fires and clears
		pending_reqs.push_back(timer_access(FUNC_PULSE, 2, 1'b1, 150, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_PULSE, 2, 1'b1, 150, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_ON, 0, 1'b0, 0, 1'b0));
		// off-delay count-down clamps at zero, then drops
		pending_reqs.push_back(timer_access(FUNC_OFF, 3, 1'b0, 50, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_OFF, 3, 1'b0, 50, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_OFF, 4, 1'b0, 0, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_OFF, 1, 1'b0, 20'hFFFFF, 1'b1));
		// top timer left untouched across this sweep, so its count is cleared
		pending_reqs.push_back(scan_update(0));
		pending_reqs.push_back(timer_access(FUNC_ON, 63, 1'b1, 20'hFFFFF, 1'b1));
		pending_reqs.push_back(timer_access(FUNC_ON, 5, 1'b1, 0, 1'b0));
		pending_reqs.push_back(scan_update(1));
		pending_reqs.push_back(timer_access(FUNC_PULSE, 5, 1'b1, 1, 1'b0));
		pending_reqs.push_back(timer_access(FUNC_ON, 62, 1'b1, 1, 1'b1));
		pending_reqs.push_back(timer_access(FUNC_OFF, 1, 1'b0, 0, 1'b0));

		// random scans over a working set, with some noise in between
		scans       = 0;
		elapsed_top = 500;
		while (pending_reqs.size() < ITEM_TARGET) begin
			if (scans % 20 == 0) begin
				// new timer program
				case ($urandom_range(0, 3))
					0:       elapsed_top = 50;
					1:       elapsed_top = 500;
					2:       elapsed_top = 5000;
					default: elapsed_top = 65535;
				endcase
				for (int s = 0; s < WORK_SET; s++) begin
					slot_id[s]    = $urandom_range(0, NUM_TIMERS - 1);
					slot_func[s]  = func_t'($urandom_range(FUNC_ON, FUNC_PULSE));
					slot_start[s] = 1'($urandom_range(0, 1));
					slot_secs[s]  = ($urandom_range(0, 7) == 0);
					if (slot_secs[s])
						slot_delay[s] = $urandom_range(0, 3);
					else if ($urandom_range(0, 15) == 0)
						slot_delay[s] = $urandom_range(0, 20'hFFFFF);
					else
						slot_delay[s] = $urandom_range(0, 4000);
				end
			end
			scans++;
			if ($urandom_range(0, 6) == 0) begin
				// noise: fully random requests
				burst = $urandom_range(1, 4);
				for (int n = 0; n < burst; n++)
					pending_reqs.push_back(timer_access(func_t'($urandom_range(0, 3)),
						$urandom_range(0, 63), 1'($urandom_range(0, 1)),
						$urandom_range(0, 20'hFFFFF), 1'($urandom_range(0, 1))));
			end else begin
				pending_reqs.push_back(scan_update(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 65535) : $urandom_range(0, elapsed_top)));
				for (int s = 0; s < WORK_SET; s++) begin
					if ($urandom_range(0, 4) == 0)
						slot_start[s] = ~slot_start[s];
					// some timers skipped this scan, so the sweep clears them
					if ($urandom_range(0, 9) < 8) begin
						pending_reqs.push_back(timer_access(slot_func[s], slot_id[s],
							slot_start[s], slot_delay[s], slot_secs[s]));
						if ($urandom_range(0, 9) == 0)
							pending_reqs.push_back(timer_access(slot_func[s], slot_id[s],
								slot_start[s], slot_delay[s], slot_secs[s]));
					end
				end
			end
		end

		// reset, then the block clears its ram before taking requests
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_ch.valid || expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (faults == 0 && expected_levels.size() == 0)
			$display("scan_cycle_delay_timer_bank_unit: match");
		else
			$display("scan_cycle_delay_timer_bank_unit: mismatch");
		$finish;
	end

endmodule
